### src/ffpa_pkg.sv
// ---------------------------------------------------------------------------
// ffpa_pkg
// Shared sizes, codes and field layout of the first-fit partition allocator.
// ---------------------------------------------------------------------------
package ffpa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  // Fixed field widths of the stream items.
  localparam int KIND_W    = 2;
  localparam int SIZE_IN_W = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 4;
  localparam int FRAG_W    = 20;

  localparam int IN_DATA_W  = SIZE_IN_W;
  localparam int OUT_FIELDS = OUT_IDX_W + 2 * FRAG_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FIELDS;

  // The accumulator adder is wide enough to see any overflow past FRAG_MAX.
  localparam int SUM_W = ((SIZE_BITS > FRAG_W) ? SIZE_BITS : FRAG_W) + 1;

  localparam logic [FRAG_W-1:0] FRAG_MAX = '1;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_LOAD    = 2'd0;
  localparam kind_t KIND_REQUEST = 2'd1;
  localparam kind_t KIND_CLEAR   = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NOT_ALLOC = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;

endpackage

### src/first_fit_partition_allocator_core.sv
// ---------------------------------------------------------------------------
// first_fit_partition_allocator_core
// Fixed-partition table with first-fit allocation and fragmentation sums.
//
//   Channel  Direction  tdata                  tuser
//   s_axis   in         size_value[15:0]       kind[1:0]
//   m_axis   out        block_index, internal  status[1:0]
//                       and external frag
//
// Every transaction, a clear included, is followed by one pass over the loaded
// entries, one entry per cycle through the partition RAM's read port; the
// same pass finds the first fit and accumulates both sums. The input is not
// ready while a pass runs. A finished result waits in the output register,
// and the next transaction is accepted meanwhile. Reset empties the table.
// ---------------------------------------------------------------------------
module first_fit_partition_allocator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ffpa_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // size_value
  input  logic [ffpa_pkg::KIND_W-1:0]      s_axis_tuser_i,  // kind
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // block_index, internal_frag, external_frag, zero fill
  output logic [ffpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic [ffpa_pkg::STATUS_W-1:0]    m_axis_tuser_o   // status
);
  import ffpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [NUM_BLOCKS-1:0] used_q, used_d;
  kind_t                 kind_q, kind_d;
  logic [SIZE_BITS-1:0]  size_q, size_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      proc_q, proc_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  status_t               res_status_q, res_status_d;
  logic [FRAG_W-1:0]     ifrag_q, ifrag_d;
  logic [FRAG_W-1:0]     efrag_q, efrag_d;

  logic                  out_valid_q, out_valid_d;
  status_t               out_status_q, out_status_d;
  logic [OUT_IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [FRAG_W-1:0]     out_ifrag_q, out_ifrag_d;
  logic [FRAG_W-1:0]     out_efrag_q, out_efrag_d;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SIZE_BITS-1:0]  ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [SIZE_BITS-1:0]  ram_rdata;

  logic                  in_fire;
  logic [SIZE_BITS:0]    diff;
  logic                  fits;
  logic                  grant;
  logic                  to_internal;
  logic [FRAG_W-1:0]     acc_in;
  logic [SIZE_BITS-1:0]  acc_val;
  logic [SUM_W-1:0]      acc_sum;
  logic [FRAG_W-1:0]     acc_sat;

  ffpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Shared datapath: one subtract-compare against the request and one
  // saturating accumulate into whichever sum the entry belongs to.
  assign diff        = {1'b0, ram_rdata} - {1'b0, size_q};
  assign fits        = !diff[SIZE_BITS];
  assign grant       = rd_vld_q && (kind_q == KIND_REQUEST) && !found_q &&
                       !used_q[proc_q] && fits;
  assign to_internal = grant || used_q[proc_q];
  assign acc_in      = to_internal ? ifrag_q : efrag_q;
  assign acc_val     = grant ? diff[SIZE_BITS-1:0] : ram_rdata;
  assign acc_sum     = SUM_W'(acc_in) + SUM_W'(acc_val);
  assign acc_sat     = (acc_sum > SUM_W'(FRAG_MAX)) ? FRAG_MAX : acc_sum[FRAG_W-1:0];

  assign ram_raddr   = scan_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    used_d       = used_q;
    kind_d       = kind_q;
    size_d       = size_q;
    scan_d       = scan_q;
    rd_vld_d     = rd_vld_q;
    proc_d       = proc_q;
    found_d      = found_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    ifrag_d      = ifrag_q;
    efrag_d      = efrag_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_ifrag_d  = out_ifrag_q;
    out_efrag_d  = out_efrag_q;
    ram_we       = 1'b0;
    ram_waddr    = proc_q;
    ram_wdata    = diff[SIZE_BITS-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d       = s_axis_tuser_i;
          size_d       = SIZE_BITS'(s_axis_tdata_i);
          scan_d       = '0;
          rd_vld_d     = 1'b0;
          found_d      = 1'b0;
          ifrag_d      = '0;
          efrag_d      = '0;
          res_idx_d    = '0;
          res_status_d = STATUS_OK;
          state_d      = ST_SCAN;
          case (s_axis_tuser_i)
            KIND_LOAD: begin
              if (count_q == CNT_W'(NUM_BLOCKS)) begin
                res_status_d = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IDX_W-1:0];
                ram_wdata = SIZE_BITS'(s_axis_tdata_i);
                res_idx_d = count_q[IDX_W-1:0];
                used_d[count_q[IDX_W-1:0]] = 1'b0;
                count_d   = count_q + CNT_W'(1);
              end
            end
            KIND_REQUEST: begin
              res_status_d = STATUS_NOT_ALLOC;
            end
            KIND_CLEAR: begin
              count_d = '0;
              used_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry's data is evaluated.
        if (scan_q < count_q) begin
          scan_d   = scan_q + CNT_W'(1);
          rd_vld_d = 1'b1;
          proc_d   = scan_q[IDX_W-1:0];
        end else begin
          rd_vld_d = 1'b0;
          state_d  = ST_DONE;
        end

        if (rd_vld_q) begin
          if (grant) begin
            found_d        = 1'b1;
            res_idx_d      = proc_q;
            res_status_d   = STATUS_OK;
            used_d[proc_q] = 1'b1;
            ram_we         = 1'b1;
          end
          if (to_internal) begin
            ifrag_d = acc_sat;
          end else begin
            efrag_d = acc_sat;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = OUT_IDX_W'(res_idx_q);
          out_ifrag_d  = ifrag_q;
          out_efrag_d  = efrag_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      used_q       <= '0;
      kind_q       <= KIND_LOAD;
      size_q       <= '0;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      proc_q       <= '0;
      found_q      <= 1'b0;
      res_idx_q    <= '0;
      res_status_q <= STATUS_OK;
      ifrag_q      <= '0;
      efrag_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_idx_q    <= '0;
      out_ifrag_q  <= '0;
      out_efrag_q  <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      used_q       <= used_d;
      kind_q       <= kind_d;
      size_q       <= size_d;
      scan_q       <= scan_d;
      rd_vld_q     <= rd_vld_d;
      proc_q       <= proc_d;
      found_q      <= found_d;
      res_idx_q    <= res_idx_d;
      res_status_q <= res_status_d;
      ifrag_q      <= ifrag_d;
      efrag_q      <= efrag_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_ifrag_q  <= out_ifrag_d;
      out_efrag_q  <= out_efrag_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_efrag_q, out_ifrag_q, out_idx_q};

endmodule

### src/ffpa_ram.sv
// ---------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives load, request and clear transactions into the first-fit partition
// allocator, mirrors its table in a behavioral predictor, and compares every
// reply field by field, with random idling on both stream sides.
// ---------------------------------------------------------------------------
module testbench;
  import ffpa_pkg::*;

  // The kind code the allocator leaves unused; it must answer with the sums.
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int    STALL_LIMIT = 2000;
  localparam int    TAIL_CYCLES = 40;
  localparam int    RANDOM_ITEMS = 850;

  typedef struct {
    kind_t                kind;
    logic [SIZE_IN_W-1:0] size_value;
    bit                   wait_drain;  // hold back until every reply is in
  } alloc_op_t;

  typedef struct {
    status_t              status;
    logic [OUT_IDX_W-1:0] block_index;
    logic [FRAG_W-1:0]    internal_frag;
    logic [FRAG_W-1:0]    external_frag;
  } alloc_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // size_value
  logic [KIND_W-1:0]     s_axis_tuser  = '0;  // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // block_index, internal, external
  logic [STATUS_W-1:0]   m_axis_tuser;        // status

  first_fit_partition_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  alloc_op_t    pending_ops[$];
  alloc_reply_t expected_replies[$];

  // Mirror of the partition table.
  logic [SIZE_IN_W-1:0] part_size [NUM_BLOCKS];
  bit                   part_used [NUM_BLOCKS];
  int                   part_count = 0;

  int  error_count = 0;
  int  n_loads = 0, n_full = 0, n_grants = 0, n_no_fit = 0, n_clears = 0;
  int  n_unused = 0, n_replies = 0;
  int  cycle_count = 0;
  int  quiet_cycles = 0;
  logic in_fire = 1'b0;

  function automatic alloc_reply_t first_fit_step(alloc_op_t op);
    alloc_reply_t    r;
    logic [FRAG_W:0] in_sum;
    logic [FRAG_W:0] ex_sum;
    r.status        = STATUS_OK;
    r.block_index   = '0;
    r.internal_frag = '0;
    r.external_frag = '0;
    in_sum = '0;
    ex_sum = '0;
    case (op.kind)
      KIND_LOAD: begin
        if (part_count >= NUM_BLOCKS) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          part_size[part_count] = op.size_value;
          part_used[part_count] = 1'b0;
          r.block_index = OUT_IDX_W'(part_count);
          part_count++;
          n_loads++;
        end
      end
      KIND_REQUEST: begin
        r.status = STATUS_NOT_ALLOC;
        for (int j = 0; j < part_count; j++) begin
          if (!part_used[j] && part_size[j] >= op.size_value) begin
            part_used[j] = 1'b1;
            part_size[j] = part_size[j] - op.size_value;
            r.status = STATUS_OK;
            r.block_index = OUT_IDX_W'(j);
            break;
          end
        end
        if (r.status == STATUS_OK) n_grants++;
        else n_no_fit++;
      end
      KIND_CLEAR: begin
        for (int j = 0; j < NUM_BLOCKS; j++) part_used[j] = 1'b0;
        part_count = 0;
        n_clears++;
      end
      default: n_unused++;
    endcase
    // Both sums saturate, although the default table size cannot reach it.
    for (int j = 0; j < part_count; j++) begin
      if (part_used[j]) begin
        in_sum = in_sum + part_size[j];
        if (in_sum > FRAG_MAX) in_sum = {1'b0, FRAG_MAX};
      end else begin
        ex_sum = ex_sum + part_size[j];
        if (ex_sum > FRAG_MAX) ex_sum = {1'b0, FRAG_MAX};
      end
    end
    r.internal_frag = in_sum[FRAG_W-1:0];
    r.external_frag = ex_sum[FRAG_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic push_op(kind_t kind, logic [SIZE_IN_W-1:0] size_value);
    alloc_op_t op;
    op.kind       = kind;
    op.size_value = size_value;
    op.wait_drain = 1'b0;
    pending_ops.push_back(op);
  endtask

  // Small sizes so that requests often fit, full-range sizes and both extremes.
  function automatic logic [SIZE_IN_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 4) return SIZE_IN_W'($urandom_range(0, 255));
    return SIZE_IN_W'($urandom);
  endfunction

  // A clear, a run of loads that sometimes overfills the table, then a mix
  // that is mostly requests with some late loads, unused kinds and clears.
  task automatic add_episode();
    int n_load;
    int n_mix;
    int r;
    n_load = $urandom_range(0, 18);
    n_mix  = $urandom_range(4, 24);
    push_op(KIND_CLEAR, SIZE_IN_W'($urandom));
    repeat (n_load) push_op(KIND_LOAD, pick_size());
    repeat (n_mix) begin
      r = $urandom_range(0, 99);
      if (r < 75)      push_op(KIND_REQUEST, pick_size());
      else if (r < 92) push_op(KIND_LOAD, pick_size());
      else if (r < 97) push_op(KIND_UNUSED, SIZE_IN_W'($urandom));
      else             push_op(KIND_CLEAR, SIZE_IN_W'($urandom));
    end
  endtask

  // Driver: inputs change on the falling edge.
  always @(negedge clk_i) begin
    bit steady;
    steady = (cycle_count >= 3000) && (cycle_count < 5000);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_ops.size() != 0 &&
            !(pending_ops[0].wait_drain && expected_replies.size() != 0) &&
            (steady || $urandom_range(0, 99) >= 15)) begin
          s_axis_tdata  <= pending_ops[0].size_value;
          s_axis_tuser  <= pending_ops[0].kind;
          s_axis_tvalid <= 1'b1;
          void'(pending_ops.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  // Monitor: predicts on each accepted input and checks each accepted reply.
  always @(posedge clk_i) begin
    alloc_reply_t got;
    alloc_reply_t want;
    alloc_op_t    op;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = m_axis_tuser;
        got.block_index   = m_axis_tdata[OUT_IDX_W-1:0];
        got.internal_frag = m_axis_tdata[OUT_IDX_W +: FRAG_W];
        got.external_frag = m_axis_tdata[OUT_IDX_W + FRAG_W +: FRAG_W];
        n_replies++;
        if (expected_replies.size() == 0) begin
          $error("reply with no transaction pending: status %0d index %0d",
                 got.status, got.block_index);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, got.status);
          check_field("block_index", want.block_index, got.block_index);
          check_field("internal_frag", want.internal_frag, got.internal_frag);
          check_field("external_frag", want.external_frag, got.external_frag);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op.kind       = s_axis_tuser;
        op.size_value = s_axis_tdata;
        op.wait_drain = 1'b0;
        expected_replies.push_back(first_fit_step(op));
      end
      in_fire <= s_axis_tvalid && s_axis_tready;
    end
  end

  // Watchdog on cycles in which neither side completes a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int directed;
    // Empty table, then blocks with the extreme sizes.
    push_op(KIND_REQUEST, 16'd5);
    push_op(KIND_LOAD, 16'd0);
    push_op(KIND_LOAD, 16'hFFFF);
    push_op(KIND_LOAD, 16'd100);
    push_op(KIND_LOAD, 16'd1);
    push_op(KIND_REQUEST, 16'd0);      // zero size takes the first free block
    push_op(KIND_REQUEST, 16'hFFFF);   // exact fit, leftover zero
    push_op(KIND_REQUEST, 16'd50);
    push_op(KIND_REQUEST, 16'd200);    // nothing free is large enough
    push_op(KIND_UNUSED, 16'hABCD);
    for (int j = 0; j < NUM_BLOCKS - 4; j++)
      push_op(KIND_LOAD, (j % 2) ? 16'hAAAA : 16'h5555);
    push_op(KIND_LOAD, 16'h1234);      // table is full now
    push_op(KIND_REQUEST, 16'hAAAA);
    push_op(KIND_CLEAR, 16'hFFFF);
    push_op(KIND_REQUEST, 16'd0);      // nothing loaded after the clear
    directed = pending_ops.size();

    while (pending_ops.size() < directed + RANDOM_ITEMS) add_episode();
    pending_ops[directed].wait_drain = 1'b1;
    pending_ops[directed + RANDOM_ITEMS / 2].wait_drain = 1'b1;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d replies: %0d loads, %0d full-table loads, %0d grants,",
             n_replies, n_loads, n_full, n_grants);
    $display("  %0d requests without a fit, %0d clears, %0d unused-kind items.",
             n_no_fit, n_clears, n_unused);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
src/ffpa_pkg.sv
src/ffpa_ram.sv
src/first_fit_partition_allocator_core.sv
sim/testbench.sv
